// ----- sv/one_shot_periodic_timer_bank_defines.svh -----
// Assertion macros for the timer bank RTL.
`ifndef ONE_SHOT_PERIODIC_TIMER_BANK_DEFINES_SVH
`define ONE_SHOT_PERIODIC_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OSPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define OSPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ospt_pkg.sv -----
// Shared types and constants for the timer bank.
package ospt_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_W         = 32;
  localparam int KIND_W         = 2;
  localparam int TIMER_ID_W     = 4;
  localparam int RESULT_SLOTS   = 16;
  localparam int SLOT_CNT_W     = $clog2(RESULT_SLOTS + 1);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

// ----- sv/ospt_ram.sv -----
// Generic simple dual-port RAM, one write port, registered read.
module ospt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/ospt_alu.sv -----
// Shared 32-bit add/subtract unit used by the sweep sequencer.
module ospt_alu (
  input  logic [ospt_pkg::TIME_W-1:0] a,
  input  logic [ospt_pkg::TIME_W-1:0] b,
  input  ospt_pkg::alu_op_t           op,
  output logic [ospt_pkg::TIME_W-1:0] sum
);
  import ospt_pkg::*;

  logic                sub;
  logic [TIME_W-1:0]   b_inv;

  assign sub   = (op == ALU_SUB);
  assign b_inv = b ^ {TIME_W{sub}};
  assign sum   = a + b_inv + TIME_W'(sub);

endmodule

// ----- sv/one_shot_periodic_timer_bank.sv -----
// Top level of the timer bank: sequencer, armed flags and result register.
//
// A bank of NUM_TIMERS timers swept by one shared 32-bit adder. A word is
// accepted on the rising edge where start is high and busy is low. A stop
// word takes effect at once and leaves busy low. A start word keeps busy high
// while the adder forms last_time + delay. A tick word records now_tick as
// the new last time and then walks the timers in index order: an S_READ
// step per timer to look at its armed flag and, if it is armed, read its
// expiry and reload words from RAM, an S_CMP step for each armed timer (the
// adder forms now - expiry, expired when the sign bit is clear), an S_UPD
// step for each expired periodic timer (the adder forms expiry + reload and
// writes it back), and a final S_DONE step to flush the last result. Results
// appear on out_valid for exactly one cycle each, in timer index order, and
// the receiver cannot hold them off. Each result is held back until the next
// expiry or the end of the sweep is known, so that out_last_expiry can be set
// on the final one of the tick. Only the first 16 expiries of a tick are
// reported; all timers are still updated.
// Expiry and reload words are never cleared; they are only read for armed
// timers, which have always been written.
`include "one_shot_periodic_timer_bank_defines.svh"

module one_shot_periodic_timer_bank #(
  parameter int NUM_TIMERS = ospt_pkg::NUM_TIMERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ospt_pkg::KIND_W-1:0]      in_kind,
  input  logic [ospt_pkg::TIMER_ID_W-1:0]  in_timer_id,
  input  logic [ospt_pkg::TIME_W-1:0]      in_now_tick,
  input  logic [ospt_pkg::TIME_W-1:0]      in_delay,
  input  logic [ospt_pkg::TIME_W-1:0]      in_period,
  output logic                             out_valid,
  output logic [ospt_pkg::TIMER_ID_W-1:0]  out_expired_timer,
  output logic                             out_is_periodic,
  output logic                             out_last_expiry
);
  import ospt_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ARM  = 6'b000010,  // write new expiry and reload
    S_READ = 6'b000100,  // check armed flag, issue RAM read
    S_CMP  = 6'b001000,  // now - expiry, record expiry
    S_UPD  = 6'b010000,  // expiry + reload, write back
    S_DONE = 6'b100000   // flush held result as last
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [NUM_TIMERS-1:0]   armed_r, armed_nxt;
  logic [TIME_W-1:0]       last_time_r, last_time_nxt;
  logic [TIME_W-1:0]       delay_r, delay_nxt;
  logic [TIME_W-1:0]       period_r, period_nxt;
  logic [SLOT_CNT_W-1:0]   cnt_r, cnt_nxt;

  // held result, sent once the next expiry or the end of sweep is known
  logic                    pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]        pend_idx_r, pend_idx_nxt;
  logic                    pend_per_r, pend_per_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [TIMER_ID_W-1:0]   out_timer_r, out_timer_nxt;
  logic                    out_per_r, out_per_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    accept;
  logic                    id_in_range;
  logic                    last_idx;

  // shared adder
  logic [TIME_W-1:0]       alu_a, alu_b, alu_sum;
  alu_op_t                 alu_op;

  // RAM ports
  logic                    exp_we, rel_we, ram_re;
  logic [TIME_W-1:0]       exp_rd, rel_rd;

  assign accept      = start && !busy;
  assign busy        = (state_r != S_IDLE);
  assign id_in_range = (32'(in_timer_id) < 32'(NUM_TIMERS));
  assign last_idx    = (idx_r == IDX_W'(NUM_TIMERS - 1));

  ospt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .sum (alu_sum)
  );

  ospt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_TIMERS)
  ) u_expiry_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (idx_r),
    .wdata (alu_sum),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (exp_rd)
  );

  ospt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_TIMERS)
  ) u_reload_ram (
    .clk   (clk),
    .we    (rel_we),
    .waddr (idx_r),
    .wdata (period_r),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (rel_rd)
  );

  // Adder operand selection per state.
  always_comb begin
    unique case (state_r)
      S_CMP: begin
        alu_a  = last_time_r;
        alu_b  = exp_rd;
        alu_op = ALU_SUB;
      end
      S_UPD: begin
        alu_a  = exp_rd;
        alu_b  = rel_rd;
        alu_op = ALU_ADD;
      end
      default: begin
        alu_a  = last_time_r;
        alu_b  = delay_r;
        alu_op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    armed_nxt     = armed_r;
    last_time_nxt = last_time_r;
    delay_nxt     = delay_r;
    period_nxt    = period_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_idx_nxt  = pend_idx_r;
    pend_per_nxt  = pend_per_r;
    out_valid_nxt = 1'b0;
    out_timer_nxt = out_timer_r;
    out_per_nxt   = out_per_r;
    out_last_nxt  = 1'b0;
    exp_we        = 1'b0;
    rel_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_TICK) begin
            last_time_nxt = in_now_tick;
            idx_nxt       = '0;
            cnt_nxt       = '0;
            pend_v_nxt    = 1'b0;
            state_nxt     = S_READ;
          end else if (in_kind == KIND_START && id_in_range) begin
            idx_nxt    = IDX_W'(in_timer_id);
            delay_nxt  = in_delay;
            period_nxt = in_period;
            state_nxt  = S_ARM;
          end else if (in_kind == KIND_STOP && id_in_range) begin
            armed_nxt[IDX_W'(in_timer_id)] = 1'b0;
          end
        end
      end
      S_ARM: begin
        exp_we          = 1'b1;
        rel_we          = 1'b1;
        armed_nxt[idx_r] = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_READ: begin
        if (armed_r[idx_r]) begin
          ram_re    = 1'b1;
          state_nxt = S_CMP;
        end else if (last_idx) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_CMP: begin
        if (!alu_sum[TIME_W-1]) begin
          // expired
          if (cnt_r < SLOT_CNT_W'(RESULT_SLOTS)) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_timer_nxt = TIMER_ID_W'(pend_idx_r);
              out_per_nxt   = pend_per_r;
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = idx_r;
            pend_per_nxt = (rel_rd != '0);
            cnt_nxt      = cnt_r + 1'b1;
          end
          if (rel_rd != '0) begin
            state_nxt = S_UPD;
          end else begin
            armed_nxt[idx_r] = 1'b0;
            if (last_idx) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_READ;
            end
          end
        end else if (last_idx) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_UPD: begin
        exp_we = 1'b1;
        if (last_idx) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_timer_nxt = TIMER_ID_W'(pend_idx_r);
          out_per_nxt   = pend_per_r;
          out_last_nxt  = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= '0;
      last_time_r <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      last_time_r <= last_time_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    delay_r     <= delay_nxt;
    period_r    <= period_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_per_r  <= pend_per_nxt;
    out_timer_r <= out_timer_nxt;
    out_per_r   <= out_per_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_expired_timer = out_timer_r;
  assign out_is_periodic   = out_per_r;
  assign out_last_expiry   = out_last_r;

  // results only come out of the tick sweep
  `OSPT_ASSERT_NOW(a_out_from_sweep, clk, rst_n, out_valid_r,
    $past(state_r == S_CMP || state_r == S_DONE), "result outside tick sweep")
  // a tick word always starts a sweep at timer zero
  `OSPT_ASSERT_NEXT(a_tick_sweeps, clk, rst_n, accept && in_kind == KIND_TICK,
    state_r == S_READ && idx_r == '0, "tick did not start sweep")
  // the last result of a tick leaves the block idle
  `OSPT_ASSERT_NOW(a_last_idle, clk, rst_n, out_valid_r && out_last_r,
    state_r == S_IDLE && !pend_v_r, "last result while sweep pending")
  // never more reported expiries than result slots
  `OSPT_ASSERT_NOW(a_slot_bound, clk, rst_n, 1'b1,
    cnt_r <= SLOT_CNT_W'(RESULT_SLOTS), "result slot count overflow")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the timer bank: directed and random start/stop/tick words.
module tb;
  import ospt_pkg::*;

  // Word kind the block has no use for; it must be swallowed without results.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int NTIMERS    = NUM_TIMERS_DEF;
  localparam int RAND_WORDS = 220;
  localparam int DRAIN_CYC  = 3 * NTIMERS + 8;  // longest tick sweep plus margin
  localparam int CYCLE_CAP  = 200000;

  // One word waiting to be sent. hold makes the driver wait for a quiet block first.
  typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [TIMER_ID_W-1:0] id;
    logic [TIME_W-1:0]     now;
    logic [TIME_W-1:0]     dly;
    logic [TIME_W-1:0]     per;
    bit                    hold;
  } word_t;

  // One predicted expiry.
  typedef struct packed {
    logic [TIMER_ID_W-1:0] timer;
    logic                  reloads;
    logic                  tail;
  } expiry_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [TIMER_ID_W-1:0] in_timer_id = '0;
  logic [TIME_W-1:0]     in_now_tick = '0;
  logic [TIME_W-1:0]     in_delay = '0;
  logic [TIME_W-1:0]     in_period = '0;
  logic                  out_valid;
  logic [TIMER_ID_W-1:0] out_expired_timer;
  logic                  out_is_periodic;
  logic                  out_last_expiry;

  one_shot_periodic_timer_bank u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_timer_id       (in_timer_id),
    .in_now_tick       (in_now_tick),
    .in_delay          (in_delay),
    .in_period         (in_period),
    .out_valid         (out_valid),
    .out_expired_timer (out_expired_timer),
    .out_is_periodic   (out_is_periodic),
    .out_last_expiry   (out_last_expiry)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  word_t   send_q[$];     // words not yet presented
  expiry_t expiry_q[$];   // expiries predicted but not yet seen

  // Shadow copy of the timer bank.
  logic [TIME_W-1:0] shadow_last;
  logic [TIME_W-1:0] shadow_due[NTIMERS];
  logic [TIME_W-1:0] shadow_interval[NTIMERS];
  bit                shadow_armed[NTIMERS];

  int  errors = 0;
  int  cycles = 0;
  int  n_ticks = 0, n_starts = 0, n_stops = 0, n_spare = 0;
  int  n_checked = 0, most_per_tick = 0;
  bit  took = 1'b0;         // word accepted at the last rising edge
  int  burst_left = 0;
  int  gap_left = 0;
  logic [TIME_W-1:0] gen_now;   // stimulus side view of the last tick time

  function automatic void note_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // Apply one accepted word to the shadow bank and queue the expiries it causes.
  function automatic void advance_bank(logic [KIND_W-1:0] kind, logic [TIMER_ID_W-1:0] id,
                                       logic [TIME_W-1:0] now, logic [TIME_W-1:0] dly,
                                       logic [TIME_W-1:0] per);
    logic [TIME_W-1:0] diff;
    bit                reload_it;
    int                hits;
    expiry_t           found[RESULT_SLOTS];
    hits = 0;
    case (kind)
      KIND_START: begin
        shadow_due[id]      = shadow_last + dly;
        shadow_interval[id] = per;
        shadow_armed[id]    = 1'b1;
        n_starts++;
      end
      KIND_STOP: begin
        shadow_armed[id] = 1'b0;
        n_stops++;
      end
      KIND_TICK: begin
        shadow_last = now;
        for (int i = 0; i < NTIMERS; i++) begin
          if (shadow_armed[i]) begin
            // wrap-safe compare: expired once the difference is non-negative
            diff = now - shadow_due[i];
            if (!diff[TIME_W-1]) begin
              reload_it = shadow_interval[i] != '0;
              if (reload_it) shadow_due[i] = shadow_due[i] + shadow_interval[i];
              else shadow_armed[i] = 1'b0;
              if (hits < RESULT_SLOTS) begin
                found[hits] = '{timer: TIMER_ID_W'(i), reloads: reload_it, tail: 1'b0};
                hits++;
              end
            end
          end
        end
        for (int k = 0; k < hits; k++) begin
          found[k].tail = (k == hits - 1);
          expiry_q.push_back(found[k]);
        end
        if (hits > most_per_tick) most_per_tick = hits;
        n_ticks++;
      end
      default: n_spare++;
    endcase
  endfunction

  // Rising edge: first check whatever the block shows, then take the word on offer.
  // Results on the port at this edge come from earlier words, so the order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expiry_q.size() == 0) begin
          note_mismatch($sformatf("unexpected expiry: timer %0d periodic %0b last %0b",
                                  out_expired_timer, out_is_periodic, out_last_expiry));
        end else begin
          expiry_t want;
          want = expiry_q.pop_front();
          n_checked++;
          if (out_expired_timer !== want.timer || out_is_periodic !== want.reloads ||
              out_last_expiry !== want.tail) begin
            note_mismatch($sformatf(
              "expiry mismatch: want timer %0d periodic %0b last %0b, got %0d %0b %0b",
              want.timer, want.reloads, want.tail,
              out_expired_timer, out_is_periodic, out_last_expiry));
          end
        end
      end
      if (start && !busy) begin
        advance_bank(in_kind, in_timer_id, in_now_tick, in_delay, in_period);
        took <= 1'b1;
      end else begin
        took <= 1'b0;
      end
    end else begin
      took <= 1'b0;
    end
  end

  // Falling edge driver: bursts of words with random gaps. A held word waits
  // until every predicted expiry has come out; busy takes care of the rest.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (send_q.size() > 0 && (!send_q[0].hold || expiry_q.size() == 0)) begin
        word_t w;
        w = send_q.pop_front();
        in_kind     <= w.kind;
        in_timer_id <= w.id;
        in_now_tick <= w.now;
        in_delay    <= w.dly;
        in_period   <= w.per;
        start       <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d expiries outstanding", cycles, expiry_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void queue_word(logic [KIND_W-1:0] kind, logic [TIMER_ID_W-1:0] id,
                                     logic [TIME_W-1:0] now, logic [TIME_W-1:0] dly,
                                     logic [TIME_W-1:0] per, bit hold);
    send_q.push_back('{kind: kind, id: id, now: now, dly: dly, per: per, hold: hold});
    if (kind == KIND_TICK) gen_now = now;
  endfunction

  // Tick that moves time forward a little, now and then by a random stride.
  function automatic void queue_tick(bit hold);
    logic [TIME_W-1:0] step;
    step = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 12);
    queue_word(KIND_TICK, TIMER_ID_W'($urandom), gen_now + step, $urandom, $urandom, hold);
  endfunction

  function automatic logic [TIME_W-1:0] pick_delay();
    return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
  endfunction

  function automatic logic [TIME_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 11);
    if (r < 3) return '0;
    if (r == 11) return $urandom;
    return $urandom_range(1, 15);
  endfunction

  initial begin
    int directed_n;
    int n_arm;
    shadow_last = '0;
    for (int i = 0; i < NTIMERS; i++) begin
      shadow_armed[i]    = 1'b0;
      shadow_due[i]      = '0;
      shadow_interval[i] = '0;
    end
    gen_now = '0;

    // Directed: empty tick, one-shot and periodic arms, half-range boundary
    // (exactly 2^31 apart is not yet due), restart of an armed timer, stop of
    // an idle timer, the spare kind, and expiry times that wrap past zero.
    queue_word(KIND_TICK,  4'd0,  32'h0,        32'h0,        32'h0,        1'b0);
    queue_word(KIND_START, 4'd0,  32'h0,        32'h0,        32'h0,        1'b0);
    queue_word(KIND_START, 4'd15, 32'h0,        32'd5,        32'd3,        1'b0);
    queue_word(KIND_START, 4'd9,  32'h0,        32'h8000_0000, 32'h0,       1'b0);
    queue_word(KIND_START, 4'd4,  32'h0,        32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_word(KIND_SPARE, 4'hF,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_word(KIND_STOP,  4'd3,  32'h0,        32'h0,        32'h0,        1'b0);
    queue_word(KIND_TICK,  4'd0,  32'h0,        32'h0,        32'h0,        1'b0);
    queue_word(KIND_TICK,  4'd5,  32'h7FFF_FFFF, 32'h0,       32'h0,        1'b0);
    queue_word(KIND_START, 4'd15, 32'h0,        32'd100,      32'h0,        1'b0);
    queue_word(KIND_STOP,  4'd4,  32'h0,        32'h0,        32'h0,        1'b0);
    queue_word(KIND_TICK,  4'd0,  32'h8000_0063, 32'h0,       32'h0,        1'b0);
    queue_word(KIND_TICK,  4'd0,  32'hFFFF_FFF0, 32'h0,       32'h0,        1'b0);
    queue_word(KIND_START, 4'd1,  32'h0,        32'h20,       32'h0,        1'b0);
    queue_word(KIND_START, 4'd2,  32'h0,        32'h0,        32'd1,        1'b0);
    queue_word(KIND_TICK,  4'd0,  32'hFFFF_FFFF, 32'h0,       32'h0,        1'b0);
    queue_word(KIND_TICK,  4'd0,  32'h10,       32'h0,        32'h0,        1'b0);
    queue_word(KIND_STOP,  4'd2,  32'h0,        32'h0,        32'h0,        1'b0);
    queue_word(KIND_TICK,  4'd0,  32'h10,       32'h0,        32'h0,        1'b0);
    directed_n = send_q.size();

    // Random: mostly arm-then-tick sequences, some full-bank sweeps, stops, and noise.
    while (send_q.size() < directed_n + RAND_WORDS) begin
      case ($urandom_range(0, 9))
        6: begin
          // every timer due together: the widest tick
          for (int i = 0; i < NTIMERS; i++)
            queue_word(KIND_START, TIMER_ID_W'(i), $urandom, $urandom_range(0, 2),
                       pick_period(), 1'b0);
          queue_word(KIND_TICK, TIMER_ID_W'($urandom), gen_now + 3, $urandom, $urandom,
                     1'b0);
        end
        7: begin
          repeat ($urandom_range(1, 3))
            queue_word(KIND_STOP, TIMER_ID_W'($urandom), $urandom, $urandom, $urandom,
                       1'b0);
          queue_tick(1'b0);
        end
        8, 9: begin
          repeat ($urandom_range(1, 3))
            queue_word(KIND_W'($urandom), TIMER_ID_W'($urandom), $urandom, $urandom,
                       $urandom, 1'b0);
        end
        default: begin
          n_arm = $urandom_range(1, 5);
          repeat (n_arm)
            queue_word(KIND_START, TIMER_ID_W'($urandom), $urandom, pick_delay(),
                       pick_period(), 1'b0);
          if ($urandom_range(0, 3) == 0)
            queue_word(KIND_STOP, TIMER_ID_W'($urandom), $urandom, $urandom, $urandom,
                       1'b0);
          repeat ($urandom_range(1, 4)) queue_tick($urandom_range(0, 19) == 0);
        end
      endcase
    end
    // make sure at least one word waits for a fully drained block
    send_q[directed_n].hold = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (send_q.size() != 0 || start) @(posedge clk);
    while (expiry_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("ran %0d ticks, %0d starts, %0d stops, %0d spare-kind words",
             n_ticks, n_starts, n_stops, n_spare);
    $display("checked %0d expiries, widest tick gave %0d, %0d mismatches",
             n_checked, most_per_tick, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
